// File: sv/pes_pkg.sv
// Constants, register codes and shared types for the particle equation of state pipeline.
package pes_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int TAG_W      = 16;
   localparam int DENS_W     = 32;
   localparam int PRESS_W    = 48;
   localparam int BULK_W     = 48;
   localparam int EXP_W      = 4;
   localparam int MAX_EXP    = (1 << EXP_W) - 1;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 48;

   localparam int LIMB_W     = 32;
   localparam int POW_FRAC   = 32;
   localparam int Q_W        = 2 * POW_FRAC;
   localparam int P_W        = POW_FRAC + PRESS_W;
   localparam int PROD_W     = P_W + Q_W;

   localparam int RGAS_W     = 36;
   localparam int DT_W       = 2 * DENS_W;
   localparam int GA_W       = LIMB_W + RGAS_W;
   localparam int GAS_N_W    = DT_W + RGAS_W;
   localparam int DIV_W      = DENS_W + FRAC_BITS;

   localparam logic [RGAS_W-1:0]  RGAS       = 36'd35708358099;
   localparam logic [P_W-1:0]     POW_ONE    = P_W'(1) << POW_FRAC;
   localparam logic [PRESS_W-1:0] PRESS_MAX  = {1'b0, {(PRESS_W-1){1'b1}}};
   localparam logic [PRESS_W-1:0] PRESS_MIN  = {1'b1, {(PRESS_W-1){1'b0}}};

   localparam logic MODE_TAIT = 1'b0;
   localparam logic MODE_GAS  = 1'b1;

   localparam logic [CFG_IDX_W-1:0] REG_EOS_MODE     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_DENSITY_REF  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_BULK_MODULUS = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_EXPONENT     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_MOLAR_MASS   = 3'd5;

   localparam logic [DENS_W-1:0] RST_DENSITY_REF  = 32'd65536000;
   localparam logic [BULK_W-1:0] RST_BULK_MODULUS = 48'd6553600000;
   localparam logic [EXP_W-1:0]  RST_EXPONENT     = 4'd7;
   localparam logic [DENS_W-1:0] RST_TEMPERATURE  = 32'd19202048;
   localparam logic [DENS_W-1:0] RST_MOLAR_MASS   = 32'd124554051;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             sat;
   } item_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             sat;
      logic             neg;
      logic [P_W-1:0]   pw;
      logic [Q_W-1:0]   rt;
   } mul_side_type;

endpackage

// File: sv/pes_div_cell.sv
// One restoring division cell: produces one quotient bit per request and hands it on.
module pes_div_cell
   import pes_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DIV_W-1:0] divisor,
   input  logic             in_valid,
   input  item_type         in_item,
   input  logic [DIV_W-1:0] in_rem,
   input  logic [Q_W-1:0]   in_low,
   output logic             out_valid,
   output item_type         out_item,
   output logic [DIV_W-1:0] out_rem,
   output logic [Q_W-1:0]   out_low
);

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             ge;
   logic             valid_in, valid_ff;
   item_type         item_in, item_ff;
   logic [DIV_W-1:0] rem_in, rem_ff;
   logic [Q_W-1:0]   low_in, low_ff;

   always_comb begin
      trial    = {in_rem, in_low[Q_W-1]};
      ge       = trial >= {1'b0, divisor};
      diff     = trial - {1'b0, divisor};
      rem_in   = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_in   = {in_low[Q_W-2:0], ge};
      item_in  = in_item;
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;

endmodule

// File: sv/pes_mul.sv
// Four-stage 80 x 64 bit multiplier built from 32-bit partial products, with sideband.
module pes_mul
   import pes_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [P_W-1:0]    in_a,
   input  logic [Q_W-1:0]    in_b,
   input  mul_side_type      in_side,
   output logic              out_valid,
   output logic [PROD_W-1:0] out_prod,
   output mul_side_type      out_side
);

   localparam int TOP_W = P_W - 2 * LIMB_W;
   localparam int PP_W  = 2 * LIMB_W;
   localparam int PT_W  = TOP_W + LIMB_W;
   localparam int ROW_W = 3 * LIMB_W;
   localparam int RT_W  = TOP_W + 2 * LIMB_W;
   localparam int SUM_W = 4 * LIMB_W;

   logic [3:0]        valid_in, valid_ff;
   mul_side_type      side_in [0:3];
   mul_side_type      side_ff [0:3];

   logic [PP_W-1:0]   pp00_in, pp01_in, pp10_in, pp11_in;
   logic [PP_W-1:0]   pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [PT_W-1:0]   pp20_in, pp21_in, pp20_ff, pp21_ff;
   logic [ROW_W-1:0]  row0_in, row1_in, row0_ff, row1_ff;
   logic [RT_W-1:0]   row2_in, row2_ff, row2b_in, row2b_ff;
   logic [SUM_W-1:0]  sum_in, sum_ff;
   logic [PROD_W-1:0] prod_in, prod_ff;

   always_comb begin
      valid_in = {valid_ff[2:0], in_valid};
      side_in[0] = in_side;
      side_in[1] = side_ff[0];
      side_in[2] = side_ff[1];
      side_in[3] = side_ff[2];

      pp00_in = PP_W'(in_a[LIMB_W-1:0]) * PP_W'(in_b[LIMB_W-1:0]);
      pp01_in = PP_W'(in_a[LIMB_W-1:0]) * PP_W'(in_b[2*LIMB_W-1:LIMB_W]);
      pp10_in = PP_W'(in_a[2*LIMB_W-1:LIMB_W]) * PP_W'(in_b[LIMB_W-1:0]);
      pp11_in = PP_W'(in_a[2*LIMB_W-1:LIMB_W]) * PP_W'(in_b[2*LIMB_W-1:LIMB_W]);
      pp20_in = PT_W'(in_a[P_W-1:2*LIMB_W]) * PT_W'(in_b[LIMB_W-1:0]);
      pp21_in = PT_W'(in_a[P_W-1:2*LIMB_W]) * PT_W'(in_b[2*LIMB_W-1:LIMB_W]);

      row0_in = ROW_W'(pp00_ff) + {pp01_ff, {LIMB_W{1'b0}}};
      row1_in = ROW_W'(pp10_ff) + {pp11_ff, {LIMB_W{1'b0}}};
      row2_in = RT_W'(pp20_ff) + {pp21_ff, {LIMB_W{1'b0}}};

      sum_in   = SUM_W'(row0_ff) + {row1_ff, {LIMB_W{1'b0}}};
      row2b_in = row2_ff;

      prod_in = PROD_W'(sum_ff) + {row2b_ff, {(2*LIMB_W){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff  <= side_in;
      pp00_ff  <= pp00_in;
      pp01_ff  <= pp01_in;
      pp10_ff  <= pp10_in;
      pp11_ff  <= pp11_in;
      pp20_ff  <= pp20_in;
      pp21_ff  <= pp21_in;
      row0_ff  <= row0_in;
      row1_ff  <= row1_in;
      row2_ff  <= row2_in;
      sum_ff   <= sum_in;
      row2b_ff <= row2b_in;
      prod_ff  <= prod_in;
   end

   assign out_valid = valid_ff[3];
   assign out_prod  = prod_ff;
   assign out_side  = side_ff[3];

endmodule

// File: sv/pes_pow_cell.sv
// One power cell: multiplies the running power by the density ratio when enabled.
module pes_pow_cell
   import pes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         in_valid,
   input  mul_side_type in_side,
   output logic         out_valid,
   output mul_side_type out_side
);

   logic              mul_valid;
   logic [PROD_W-1:0] mul_prod;
   mul_side_type      mul_side;
   logic              valid_in, valid_ff;
   mul_side_type      side_in, side_ff;

   pes_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_a      (in_side.pw),
      .in_b      (in_side.rt),
      .in_side   (in_side),
      .out_valid (mul_valid),
      .out_prod  (mul_prod),
      .out_side  (mul_side)
   );

   always_comb begin
      valid_in = mul_valid;
      side_in  = mul_side;
      if (enable && !mul_side.sat) begin
         side_in.pw  = mul_prod[POW_FRAC +: P_W];
         side_in.sat = |mul_prod[PROD_W-1:POW_FRAC+P_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;

endmodule

// File: sv/particle_equation_of_state.sv
// Top level of the particle equation of state pipeline (Tait or perfect gas pressure).
// Pipeline: a front (stages g1, g2, g3 and divider setup d0), 64 divider cells,
// 15 power cells of 5 stages, 6 stages of final scaling.
// Throughput: one request per cycle; busy stays low and results never wait.
// Reset (synchronous) empties the pipeline and loads the register reset values.
module particle_equation_of_state
   import pes_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [TAG_W-1:0]          req_particle_index,
   input  logic [DENS_W-1:0]         req_density,
   output logic                      rsp_strobe,
   output logic [TAG_W-1:0]          rsp_tag_out,
   output logic signed [PRESS_W-1:0] rsp_pressure,
   output logic                      rsp_saturated,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CFG_IDX_W-1:0]      csr_index,
   input  logic [CFG_DATA_W-1:0]     csr_data
);

   localparam int CMP_W = GAS_N_W + DIV_W;
   localparam int HI_W  = PROD_W - POW_FRAC;

   logic              eos_mode_in, eos_mode_ff;
   logic [DENS_W-1:0] density_ref_in, density_ref_ff;
   logic [BULK_W-1:0] bulk_modulus_in, bulk_modulus_ff;
   logic [EXP_W-1:0]  exponent_in, exponent_ff;
   logic [DENS_W-1:0] temperature_in, temperature_ff;
   logic [DENS_W-1:0] molar_mass_in, molar_mass_ff;

   logic               g1_valid_in, g1_valid_ff;
   logic [TAG_W-1:0]   g1_tag_in, g1_tag_ff;
   logic [DENS_W-1:0]  g1_dens_in, g1_dens_ff;
   logic [DT_W-1:0]    g1_dt_in, g1_dt_ff;
   logic               g2_valid_in, g2_valid_ff;
   logic [TAG_W-1:0]   g2_tag_in, g2_tag_ff;
   logic [DENS_W-1:0]  g2_dens_in, g2_dens_ff;
   logic [GA_W-1:0]    g2_pa_in, g2_pa_ff, g2_pb_in, g2_pb_ff;
   logic               g3_valid_in, g3_valid_ff;
   logic [TAG_W-1:0]   g3_tag_in, g3_tag_ff;
   logic [DENS_W-1:0]  g3_dens_in, g3_dens_ff;
   logic [GAS_N_W-1:0] g3_n_in, g3_n_ff;

   logic [DIV_W-1:0]   divisor;
   logic               gas_over;
   logic               d0_valid_in, d0_valid_ff;
   item_type           d0_item_in, d0_item_ff;
   logic [DIV_W-1:0]   d0_rem_in, d0_rem_ff;
   logic [Q_W-1:0]     d0_low_in, d0_low_ff;

   logic               div_valid [0:Q_W];
   item_type           div_item  [0:Q_W];
   logic [DIV_W-1:0]   div_rem   [0:Q_W];
   logic [Q_W-1:0]     div_low   [0:Q_W];

   logic [MAX_EXP-1:0] pow_en;
   logic               pow_valid [0:MAX_EXP];
   mul_side_type       pow_side  [0:MAX_EXP];

   logic               t1_valid_in, t1_valid_ff;
   logic [P_W-1:0]     t1_d_in, t1_d_ff;
   mul_side_type       t1_side_in, t1_side_ff;

   logic               fm_valid;
   logic [PROD_W-1:0]  fm_prod;
   mul_side_type       fm_side;

   logic [HI_W-1:0]    hi;
   logic [HI_W:0]      mag;
   logic [HI_W:0]      neg_mag;
   logic               pos_over;
   logic               neg_over;

   logic               out_valid_in, out_valid_ff;
   logic [TAG_W-1:0]   out_tag_in, out_tag_ff;
   logic [PRESS_W-1:0] out_press_in, out_press_ff;
   logic               out_sat_in, out_sat_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      eos_mode_in     = eos_mode_ff;
      density_ref_in  = density_ref_ff;
      bulk_modulus_in = bulk_modulus_ff;
      exponent_in     = exponent_ff;
      temperature_in  = temperature_ff;
      molar_mass_in   = molar_mass_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_EOS_MODE:     eos_mode_in     = csr_data[0];
            REG_DENSITY_REF:  density_ref_in  = csr_data[DENS_W-1:0];
            REG_BULK_MODULUS: bulk_modulus_in = csr_data[BULK_W-1:0];
            REG_EXPONENT:     exponent_in     = csr_data[EXP_W-1:0];
            REG_TEMPERATURE:  temperature_in  = csr_data[DENS_W-1:0];
            REG_MOLAR_MASS:   molar_mass_in   = csr_data[DENS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eos_mode_ff     <= MODE_TAIT;
         density_ref_ff  <= RST_DENSITY_REF;
         bulk_modulus_ff <= RST_BULK_MODULUS;
         exponent_ff     <= RST_EXPONENT;
         temperature_ff  <= RST_TEMPERATURE;
         molar_mass_ff   <= RST_MOLAR_MASS;
      end else begin
         eos_mode_ff     <= eos_mode_in;
         density_ref_ff  <= density_ref_in;
         bulk_modulus_ff <= bulk_modulus_in;
         exponent_ff     <= exponent_in;
         temperature_ff  <= temperature_in;
         molar_mass_ff   <= molar_mass_in;
      end
   end

   // front: density * temperature * R, then divider setup
   always_comb begin
      g1_valid_in = start && !busy;
      g1_tag_in   = req_particle_index;
      g1_dens_in  = req_density;
      g1_dt_in    = DT_W'(req_density) * DT_W'(temperature_ff);

      g2_valid_in = g1_valid_ff;
      g2_tag_in   = g1_tag_ff;
      g2_dens_in  = g1_dens_ff;
      g2_pa_in    = GA_W'(g1_dt_ff[LIMB_W-1:0]) * GA_W'(RGAS);
      g2_pb_in    = GA_W'(g1_dt_ff[DT_W-1:LIMB_W]) * GA_W'(RGAS);

      g3_valid_in = g2_valid_ff;
      g3_tag_in   = g2_tag_ff;
      g3_dens_in  = g2_dens_ff;
      g3_n_in     = GAS_N_W'(g2_pa_ff) + {g2_pb_ff, {LIMB_W{1'b0}}};

      divisor  = (eos_mode_ff == MODE_GAS) ? {molar_mass_ff, {FRAC_BITS{1'b0}}}
                                           : DIV_W'(density_ref_ff);
      gas_over = CMP_W'(g3_n_ff) >= (CMP_W'(divisor) << (PRESS_W - 1));

      d0_valid_in    = g3_valid_ff;
      d0_item_in.tag = g3_tag_ff;
      if (eos_mode_ff == MODE_GAS) begin
         d0_item_in.sat = gas_over;
         d0_rem_in      = DIV_W'(g3_n_ff[GAS_N_W-1:Q_W]);
         d0_low_in      = g3_n_ff[Q_W-1:0];
      end else begin
         d0_item_in.sat = density_ref_ff == '0;
         d0_rem_in      = '0;
         d0_low_in      = {g3_dens_ff, {POW_FRAC{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
         g2_valid_ff <= 1'b0;
         g3_valid_ff <= 1'b0;
         d0_valid_ff <= 1'b0;
      end else begin
         g1_valid_ff <= g1_valid_in;
         g2_valid_ff <= g2_valid_in;
         g3_valid_ff <= g3_valid_in;
         d0_valid_ff <= d0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g1_tag_ff  <= g1_tag_in;
      g1_dens_ff <= g1_dens_in;
      g1_dt_ff   <= g1_dt_in;
      g2_tag_ff  <= g2_tag_in;
      g2_dens_ff <= g2_dens_in;
      g2_pa_ff   <= g2_pa_in;
      g2_pb_ff   <= g2_pb_in;
      g3_tag_ff  <= g3_tag_in;
      g3_dens_ff <= g3_dens_in;
      g3_n_ff    <= g3_n_in;
      d0_item_ff <= d0_item_in;
      d0_rem_ff  <= d0_rem_in;
      d0_low_ff  <= d0_low_in;
   end

   assign div_valid[0] = d0_valid_ff;
   assign div_item[0]  = d0_item_ff;
   assign div_rem[0]   = d0_rem_ff;
   assign div_low[0]   = d0_low_ff;

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      pes_div_cell u_div_cell (
         .clock     (clock),
         .reset     (reset),
         .divisor   (divisor),
         .in_valid  (div_valid[k]),
         .in_item   (div_item[k]),
         .in_rem    (div_rem[k]),
         .in_low    (div_low[k]),
         .out_valid (div_valid[k+1]),
         .out_item  (div_item[k+1]),
         .out_rem   (div_rem[k+1]),
         .out_low   (div_low[k+1])
      );
   end

   always_comb begin
      pow_valid[0]    = div_valid[Q_W];
      pow_side[0].tag = div_item[Q_W].tag;
      pow_side[0].sat = div_item[Q_W].sat;
      pow_side[0].neg = 1'b0;
      pow_side[0].pw  = POW_ONE;
      pow_side[0].rt  = div_low[Q_W];
   end

   for (genvar j = 0; j < MAX_EXP; j++) begin : g_pow
      assign pow_en[j] = (eos_mode_ff == MODE_TAIT) && (EXP_W'(j) < exponent_ff);

      pes_pow_cell u_pow_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (pow_en[j]),
         .in_valid  (pow_valid[j]),
         .in_side   (pow_side[j]),
         .out_valid (pow_valid[j+1]),
         .out_side  (pow_side[j+1])
      );
   end

   // scale (power - 1) by the bulk modulus
   always_comb begin
      t1_valid_in = pow_valid[MAX_EXP];
      t1_side_in  = pow_side[MAX_EXP];
      if (pow_side[MAX_EXP].pw >= POW_ONE) begin
         t1_d_in        = pow_side[MAX_EXP].pw - POW_ONE;
         t1_side_in.neg = 1'b0;
      end else begin
         t1_d_in        = POW_ONE - pow_side[MAX_EXP].pw;
         t1_side_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff <= t1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_d_ff    <= t1_d_in;
      t1_side_ff <= t1_side_in;
   end

   pes_mul u_final_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t1_valid_ff),
      .in_a      (t1_d_ff),
      .in_b      (Q_W'(bulk_modulus_ff)),
      .in_side   (t1_side_ff),
      .out_valid (fm_valid),
      .out_prod  (fm_prod),
      .out_side  (fm_side)
   );

   always_comb begin
      hi       = fm_prod[PROD_W-1:POW_FRAC];
      mag      = (HI_W+1)'(hi) + (HI_W+1)'(|fm_prod[POW_FRAC-1:0]);
      neg_mag  = '0 - mag;
      pos_over = |hi[HI_W-1:PRESS_W-1];
      neg_over = mag > ((HI_W+1)'(1) << (PRESS_W - 1));

      out_valid_in = fm_valid;
      out_tag_in   = fm_side.tag;
      priority if (fm_side.sat) begin
         out_press_in = PRESS_MAX;
         out_sat_in   = 1'b1;
      end else if (eos_mode_ff == MODE_GAS) begin
         out_press_in = fm_side.rt[PRESS_W-1:0];
         out_sat_in   = 1'b0;
      end else if (!fm_side.neg) begin
         out_press_in = pos_over ? PRESS_MAX : hi[PRESS_W-1:0];
         out_sat_in   = pos_over;
      end else begin
         out_press_in = neg_over ? PRESS_MIN : neg_mag[PRESS_W-1:0];
         out_sat_in   = neg_over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tag_ff   <= out_tag_in;
      out_press_ff <= out_press_in;
      out_sat_ff   <= out_sat_in;
   end

   assign rsp_strobe    = out_valid_ff;
   assign rsp_tag_out   = out_tag_ff;
   assign rsp_pressure  = out_press_ff;
   assign rsp_saturated = out_sat_ff;

endmodule
